// ----- sv/rbs_pkg.sv -----
package rbs_pkg;

   // Configuration register indexes, in register order.
   localparam logic [2:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [2:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [2:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [2:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [2:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [2:0] CSR_BOX_MAX_Z = 3'd5;
   localparam logic [2:0] CSR_HIT_EPS   = 3'd6;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int EPS_WIDTH       = 16;
   localparam int LEN_WIDTH       = 31;

   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd66;

   typedef logic [EPS_WIDTH-1:0] eps_type;
   typedef logic [LEN_WIDTH-1:0] len_type;

endpackage

// ----- sv/rbs_req_if.sv -----
interface rbs_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] origin_x;
   logic signed [COORD_WIDTH-1:0] origin_y;
   logic signed [COORD_WIDTH-1:0] origin_z;
   logic signed [COORD_WIDTH-1:0] dir_x;
   logic signed [COORD_WIDTH-1:0] dir_y;
   logic signed [COORD_WIDTH-1:0] dir_z;
   logic                          finite_seg;
   rbs_pkg::len_type              seg_length;

   modport source (
      output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
             finite_seg, seg_length,
      input  ready
   );
   modport sink (
      input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
             finite_seg, seg_length,
      output ready
   );
endinterface

// ----- sv/rbs_rsp_if.sv -----
interface rbs_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic origin_inside;

   modport source (output valid, hit, origin_inside, input ready);
   modport sink (input valid, hit, origin_inside, output ready);
endinterface

// ----- sv/rbs_div_lane.sv -----
// Pipelined fixed-point divider: ((bound - org) << FRAC_BITS) / dir,
// truncated toward zero and saturated. One quotient bit per stage.
// Stage 0 forms magnitudes, stage 1 checks saturation, stages 2..W
// produce quotient bits W-2..0, stage W+1 applies sign and saturation.
module rbs_div_lane #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic [COORD_WIDTH+1:0]        en,
   input  logic signed [COORD_WIDTH-1:0] bound,
   input  logic signed [COORD_WIDTH-1:0] org,
   input  logic signed [COORD_WIDTH-1:0] dir,
   output logic signed [COORD_WIDTH-1:0] quot
);

   localparam int W     = COORD_WIDTH;
   localparam int NUM_W = W + 1 + FRAC_BITS;
   localparam int REM_W = (NUM_W > 2 * W - 1) ? NUM_W : 2 * W - 1;

   localparam logic [W-1:0] LIM  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

   logic [W:0]       diff_in;
   logic [W:0]       mag_in;
   logic [W:0]       mag_ff;
   logic             neg_in;
   logic             neg0_ff;
   logic [W-1:0]     den_in;
   logic [W-1:0]     den0_ff;

   logic [REM_W-1:0] rem_ff [1:W];
   logic [W-1:0]     den_ff [1:W];
   logic             neg_ff [1:W];
   logic             sat_ff [1:W];
   logic [W-2:0]     q_ff   [1:W];

   logic [REM_W-1:0] num_in;
   logic [REM_W-1:0] lim_in;
   logic [W-1:0]     mq_in;
   logic [W-1:0]     quot_in;
   logic [W-1:0]     quot_ff;

   // Stage 0: exact difference and magnitudes.
   always_comb begin
      diff_in = {bound[W-1], bound} - {org[W-1], org};
      mag_in  = diff_in[W] ? (~diff_in + 1'b1) : diff_in;
      neg_in  = diff_in[W] ^ dir[W-1];
      den_in  = dir[W-1] ? (~dir + 1'b1) : dir;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mag_ff  <= mag_in;
         neg0_ff <= neg_in;
         den0_ff <= den_in;
      end
   end

   // Stage 1: quotient overflows the signed range when num >= den << (W-1).
   always_comb begin
      num_in = REM_W'({mag_ff, {FRAC_BITS{1'b0}}});
      lim_in = REM_W'(den0_ff) << (W - 1);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rem_ff[1] <= num_in;
         den_ff[1] <= den0_ff;
         neg_ff[1] <= neg0_ff;
         sat_ff[1] <= (num_in >= lim_in);
         q_ff[1]   <= '0;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 2; k <= W; k++) begin : g_bit
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] rem_in;
      logic [W-2:0]     q_in;
      logic             ge;

      always_comb begin
         trial     = REM_W'(den_ff[k-1]) << (W - k);
         ge        = rem_ff[k-1] >= trial;
         rem_in    = ge ? (rem_ff[k-1] - trial) : rem_ff[k-1];
         q_in      = q_ff[k-1];
         q_in[W-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            q_ff[k]   <= q_in;
         end
      end
   end

   // Final stage: saturate and apply sign.
   always_comb begin
      mq_in = sat_ff[W] ? LIM : {1'b0, q_ff[W]};
      if (neg_ff[W]) begin
         quot_in = ~mq_in + 1'b1;
      end else begin
         quot_in = sat_ff[W] ? MAXP : {1'b0, q_ff[W]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[W+1]) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = signed'(quot_ff);

endmodule

// ----- sv/ray_box_slab_test.sv -----
// Channel   Dir  Beat contents
// req_if    in   ray origin, direction, finite flag, segment length
// rsp_if    out  hit, origin_inside
// csr_*     in   box corners and hit epsilon, write only
//
// One ray enters per cycle unless a stalled output has filled every stage.
// Six dividers (two per axis) run side by side; three compare stages follow.
// Reset clears the stage valid bits and sets the box to zero and epsilon to 66.
// Each stage moves whenever it is empty or the stage after it is moving, so a
// stalled output still lets bubbles close up and new rays enter.
module ray_box_slab_test #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   rbs_req_if.sink                             req_if,
   rbs_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [rbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_wr_data
);

   localparam int W  = COORD_WIDTH;
   localparam int L  = W + 2;
   localparam int SA = L;
   localparam int SB = L + 1;
   localparam int SC = L + 2;
   localparam int N  = L + 3;
   localparam int CW = ((W > rbs_pkg::LEN_WIDTH) ? W : rbs_pkg::LEN_WIDTH) + 1;

   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

   // Configuration registers.
   logic signed [W-1:0] box_lo_ff [0:2];
   logic signed [W-1:0] box_hi_ff [0:2];
   rbs_pkg::eps_type    eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_lo_ff[a] <= '0;
            box_hi_ff[a] <= '0;
         end
         eps_ff <= rbs_pkg::EPS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            rbs_pkg::CSR_BOX_MIN_X: box_lo_ff[0] <= signed'(csr_wr_data);
            rbs_pkg::CSR_BOX_MIN_Y: box_lo_ff[1] <= signed'(csr_wr_data);
            rbs_pkg::CSR_BOX_MIN_Z: box_lo_ff[2] <= signed'(csr_wr_data);
            rbs_pkg::CSR_BOX_MAX_X: box_hi_ff[0] <= signed'(csr_wr_data);
            rbs_pkg::CSR_BOX_MAX_Y: box_hi_ff[1] <= signed'(csr_wr_data);
            rbs_pkg::CSR_BOX_MAX_Z: box_hi_ff[2] <= signed'(csr_wr_data);
            rbs_pkg::CSR_HIT_EPS:   eps_ff <= csr_wr_data[rbs_pkg::EPS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Stage valid bits and per-stage advance enables.
   logic [N-1:0] v_ff;
   logic [N-1:0] en;

   always_comb begin
      en[N-1] = !v_ff[N-1] || rsp_if.ready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_if.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_if.valid;
         end
         for (int k = 1; k < N; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Entry: per-axis views of the ray.
   logic signed [W-1:0] org [0:2];
   logic signed [W-1:0] dir [0:2];
   logic [2:0]          dz_in;
   logic [2:0]          slab_in;

   always_comb begin
      org[0] = req_if.origin_x;
      org[1] = req_if.origin_y;
      org[2] = req_if.origin_z;
      dir[0] = req_if.dir_x;
      dir[1] = req_if.dir_y;
      dir[2] = req_if.dir_z;
      for (int a = 0; a < 3; a++) begin
         dz_in[a]   = (dir[a] == '0);
         slab_in[a] = (org[a] >= box_lo_ff[a]) && (org[a] <= box_hi_ff[a]);
      end
   end

   // Dividers: upper-bound and lower-bound crossing per axis.
   logic signed [W-1:0] t_hi [0:2];
   logic signed [W-1:0] t_lo [0:2];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbs_div_lane #(
         .COORD_WIDTH (W),
         .FRAC_BITS   (FRAC_BITS)
      ) u_div_hi (
         .clock (clock),
         .en    (en[L-1:0]),
         .bound (box_hi_ff[a]),
         .org   (org[a]),
         .dir   (dir[a]),
         .quot  (t_hi[a])
      );
      rbs_div_lane #(
         .COORD_WIDTH (W),
         .FRAC_BITS   (FRAC_BITS)
      ) u_div_lo (
         .clock (clock),
         .en    (en[L-1:0]),
         .bound (box_lo_ff[a]),
         .org   (org[a]),
         .dir   (dir[a]),
         .quot  (t_lo[a])
      );
   end

   // Side data travels beside the dividers.
   logic                fin_ff  [0:SB];
   rbs_pkg::len_type    len_ff  [0:SB];
   logic [2:0]          dz_ff   [0:SB];
   logic [2:0]          slab_ff [0:SB];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         fin_ff[0]  <= req_if.finite_seg;
         len_ff[0]  <= req_if.seg_length;
         dz_ff[0]   <= dz_in;
         slab_ff[0] <= slab_in;
      end
      for (int k = 1; k <= SB; k++) begin
         if (en[k]) begin
            fin_ff[k]  <= fin_ff[k-1];
            len_ff[k]  <= len_ff[k-1];
            dz_ff[k]   <= dz_ff[k-1];
            slab_ff[k] <= slab_ff[k-1];
         end
      end
   end

   // Stage A: entry and exit per axis; a parallel axis leaves the interval open.
   logic signed [W-1:0] enter_in [0:2];
   logic signed [W-1:0] leave_in [0:2];
   logic signed [W-1:0] enter_ff [0:2];
   logic signed [W-1:0] leave_ff [0:2];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (dz_ff[SA-1][a]) begin
            enter_in[a] = MINV;
            leave_in[a] = MAXV;
         end else if (t_hi[a] < t_lo[a]) begin
            enter_in[a] = t_hi[a];
            leave_in[a] = t_lo[a];
         end else begin
            enter_in[a] = t_lo[a];
            leave_in[a] = t_hi[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[SA]) begin
         for (int a = 0; a < 3; a++) begin
            enter_ff[a] <= enter_in[a];
            leave_ff[a] <= leave_in[a];
         end
      end
   end

   // Stage B: running interval after each axis in x, y, z order.
   logic signed [W-1:0] tmin_in [0:2];
   logic signed [W-1:0] tmax_in [0:2];
   logic signed [W-1:0] tmin_ff [0:2];
   logic signed [W-1:0] tmax_ff [0:2];

   always_comb begin
      tmin_in[0] = enter_ff[0];
      tmax_in[0] = leave_ff[0];
      for (int a = 1; a < 3; a++) begin
         tmin_in[a] = (enter_ff[a] > tmin_in[a-1]) ? enter_ff[a] : tmin_in[a-1];
         tmax_in[a] = (leave_ff[a] < tmax_in[a-1]) ? leave_ff[a] : tmax_in[a-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[SB]) begin
         for (int a = 0; a < 3; a++) begin
            tmin_ff[a] <= tmin_in[a];
            tmax_ff[a] <= tmax_in[a];
         end
      end
   end

   // Stage C: per-axis checks, segment checks and the output register.
   logic signed [CW-1:0] eps_e;
   logic signed [CW-1:0] len_e;
   logic signed [CW-1:0] tmin_e [0:2];
   logic signed [CW-1:0] tmax_e [0:2];
   logic [2:0]           ok;
   logic                 hit_in;
   logic                 hit_ff;
   logic                 inside_ff;

   always_comb begin
      eps_e = signed'(CW'(eps_ff));
      len_e = signed'(CW'(len_ff[SB]));
      for (int a = 0; a < 3; a++) begin
         tmin_e[a] = {{(CW-W){tmin_ff[a][W-1]}}, tmin_ff[a]};
         tmax_e[a] = {{(CW-W){tmax_ff[a][W-1]}}, tmax_ff[a]};
         if (dz_ff[SB][a]) begin
            ok[a] = slab_ff[SB][a];
         end else begin
            ok[a] = (tmin_e[a] <= tmax_e[a]) && (tmax_e[a] >= eps_e);
         end
      end
      hit_in = (&ok)
            && !(fin_ff[SB] && (tmin_e[2] > len_e))
            && !(fin_ff[SB] && (tmin_e[2] < eps_e) && (tmax_e[2] > len_e));
   end

   always_ff @(posedge clock) begin
      if (en[SC]) begin
         hit_ff    <= hit_in;
         inside_ff <= &slab_ff[SB];
      end
   end

   assign rsp_if.valid         = v_ff[SC];
   assign rsp_if.hit           = hit_ff;
   assign rsp_if.origin_inside = inside_ff;

   // Input back-pressure only comes from a full pipe behind a stalled output.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (&v_ff) && !rsp_if.ready)
      else $error("input stalled while the pipeline has a free stage");

   // No stage holds a beat right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (v_ff == '0))
      else $error("pipeline stage valid after reset");

endmodule

// ----- dv/slab_checker.sv -----
module slab_checker (
   input  logic                                clock,
   input  logic                                reset,
   rbs_req_if                                  req_if,
   rbs_rsp_if                                  rsp_if,
   input  logic                                csr_wr_en,
   input  logic [rbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                         csr_wr_data,
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic hit;
      logic origin_inside;
   } verdict_type;

   verdict_type verdict_q[$];

   // Shadow copy of the box and epsilon registers.
   logic signed [31:0] box_lo [3];
   logic signed [31:0] box_hi [3];
   rbs_pkg::eps_type   eps_shadow;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // Slab crossing parameter ((bound - org) << 16) / dir, truncated and saturated.
   function automatic longint slab_param(input longint bound, input longint org,
                                         input longint dir);
      longint unsigned mag;
      longint unsigned den;
      longint unsigned quo;
      bit              neg;
      mag = (bound >= org) ? longint'(bound - org) : longint'(org - bound);
      if (mag == 0) return 0;
      neg = (bound < org) != (dir < 0);
      den = (dir < 0) ? longint'(-dir) : longint'(dir);
      quo = (mag << 16) / den;
      if (!neg) return (quo > longint'(COORD_MAX)) ? COORD_MAX : longint'(quo);
      if (quo >= 64'd2147483648) return COORD_MIN;
      return -longint'(quo);
   endfunction

   function automatic verdict_type predict_ray();
      longint      org [3];
      longint      dir [3];
      longint      lo, hi, t1, t2, t_min, t_max, eps, len;
      bit          hit, in_box, fin;
      verdict_type v;
      org[0] = req_if.origin_x; org[1] = req_if.origin_y; org[2] = req_if.origin_z;
      dir[0] = req_if.dir_x;    dir[1] = req_if.dir_y;    dir[2] = req_if.dir_z;
      fin    = req_if.finite_seg;
      len    = longint'(req_if.seg_length);
      eps    = longint'(eps_shadow);
      t_min  = COORD_MIN;
      t_max  = COORD_MAX;
      hit    = 1'b1;
      in_box = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (hit) begin
            lo = box_lo[i];
            hi = box_hi[i];
            if (dir[i] != 0) begin
               t1 = slab_param(hi, org[i], dir[i]);
               t2 = slab_param(lo, org[i], dir[i]);
               if (t1 > t2) begin
                  lo = t2; t2 = t1; t1 = lo;
               end
               if (t1 > t_min) t_min = t1;
               if (t2 < t_max) t_max = t2;
               if (t_min > t_max || t_max < eps) hit = 1'b0;
            end else if (org[i] > hi || org[i] < lo) begin
               hit = 1'b0;
            end
            if (hit && fin && t_min > len) hit = 1'b0;
         end
      end
      // A segment lying wholly inside the box does not count as a hit.
      if (hit && fin && t_min < eps && t_max > len) hit = 1'b0;
      for (int i = 0; i < 3; i++)
         if (org[i] > longint'(box_hi[i]) || org[i] < longint'(box_lo[i])) in_box = 1'b0;
      v.hit = hit;
      v.origin_inside = in_box;
      return v;
   endfunction

   assign pending = verdict_q.size();

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_lo[i] <= '0;
            box_hi[i] <= '0;
         end
         eps_shadow <= rbs_pkg::EPS_RESET;
      end else begin
         // Predict every accepted ray beat.
         if (req_if.valid && req_if.ready) verdict_q.push_back(predict_ray());
         // Compare every accepted result beat with the oldest prediction.
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("result beat with no ray outstanding");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_if.hit !== want.hit)
                  report_mismatch($sformatf("hit got %b want %b", rsp_if.hit, want.hit));
               if (rsp_if.origin_inside !== want.origin_inside)
                  report_mismatch($sformatf("origin_inside got %b want %b",
                                            rsp_if.origin_inside, want.origin_inside));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               rbs_pkg::CSR_BOX_MIN_X: box_lo[0] <= csr_wr_data;
               rbs_pkg::CSR_BOX_MIN_Y: box_lo[1] <= csr_wr_data;
               rbs_pkg::CSR_BOX_MIN_Z: box_lo[2] <= csr_wr_data;
               rbs_pkg::CSR_BOX_MAX_X: box_hi[0] <= csr_wr_data;
               rbs_pkg::CSR_BOX_MAX_Y: box_hi[1] <= csr_wr_data;
               rbs_pkg::CSR_BOX_MAX_Z: box_hi[2] <= csr_wr_data;
               rbs_pkg::CSR_HIT_EPS:   eps_shadow <= csr_wr_data[rbs_pkg::EPS_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   initial fail_count = 0;
endmodule

// ----- dv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 45;

   logic                                clock;
   logic                                reset;
   logic                                csr_wr_en;
   logic [rbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0]                         csr_wr_data;
   int                                  fail_count;
   int                                  pending;
   int                                  idle_pct;
   int                                  stall_pct;

   // Current box, kept so that random rays can aim near it.
   int box_lo [3];
   int box_hi [3];

   rbs_req_if #(.COORD_WIDTH(32)) req_if ();
   rbs_rsp_if                     rsp_if ();

   ray_box_slab_test #(.COORD_WIDTH(32), .FRAC_BITS(16)) dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   slab_checker u_checker (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

   // Result side back-pressure.
   always @(posedge clock)
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   task automatic write_reg(input logic [rbs_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input int data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic set_box(input int lx, input int ly, input int lz,
                          input int hx, input int hy, input int hz, input int eps);
      box_lo[0] = lx; box_lo[1] = ly; box_lo[2] = lz;
      box_hi[0] = hx; box_hi[1] = hy; box_hi[2] = hz;
      write_reg(rbs_pkg::CSR_BOX_MIN_X, lx);
      write_reg(rbs_pkg::CSR_BOX_MIN_Y, ly);
      write_reg(rbs_pkg::CSR_BOX_MIN_Z, lz);
      write_reg(rbs_pkg::CSR_BOX_MAX_X, hx);
      write_reg(rbs_pkg::CSR_BOX_MAX_Y, hy);
      write_reg(rbs_pkg::CSR_BOX_MAX_Z, hz);
      write_reg(rbs_pkg::CSR_HIT_EPS, eps);
      csr_wr_en <= 1'b0;
   endtask

   // Drives one ray beat, with random gaps before it, and returns once accepted.
   task automatic send_ray(input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz,
                           input bit fin, input int len);
      bit took;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.origin_x   <= ox;
      req_if.origin_y   <= oy;
      req_if.origin_z   <= oz;
      req_if.dir_x      <= dx;
      req_if.dir_y      <= dy;
      req_if.dir_z      <= dz;
      req_if.finite_seg <= fin;
      req_if.seg_length <= len[30:0];
      do begin
         @(negedge clock);
         took = req_if.ready;
         @(posedge clock);
      end while (!took);
   endtask

   // Drops the request and waits until every ray has its result.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic int near_axis(input int a);
      longint span, v;
      span = longint'(box_hi[a]) - longint'(box_lo[a]);
      if (span < 0) span = -span;
      span = span + 64'd65536;
      v = longint'(box_lo[a]) - span / 2 + longint'($urandom_range(0, 32'(span * 2)));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return int'(v);
   endfunction

   function automatic int small_dir();
      if ($urandom_range(7) == 0) return 0;
      return $urandom_range(1, 32'h40000) * ($urandom_range(1) ? 1 : -1);
   endfunction

   task automatic random_rays(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(3) != 0)
            send_ray(near_axis(0), near_axis(1), near_axis(2),
                     small_dir(), small_dir(), small_dir(),
                     $urandom_range(1), $urandom_range(0, 32'h00400000));
         else
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(1), $urandom);
      end
   endtask

   initial begin
      int base;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.origin_x = '0; req_if.origin_y = '0; req_if.origin_z = '0;
      req_if.dir_x   = '0; req_if.dir_y = '0; req_if.dir_z = '0;
      req_if.finite_seg = 1'b0;
      req_if.seg_length = '0;
      rsp_if.ready   = 1'b0;
      idle_pct       = 0;
      stall_pct      = 0;
      box_lo = '{0, 0, 0};
      box_hi = '{0, 0, 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset box is a single point at the origin.
      send_ray(0, 0, 0, 0, 0, 0, 1'b0, 0);
      send_ray(32'h10000, 0, 0, -32'h10000, 0, 0, 1'b0, 0);
      wait_idle();

      // Directed rays against the unit box.
      set_box(-32'h10000, -32'h10000, -32'h10000, 32'h10000, 32'h10000, 32'h10000, 66);
      base = 32'h30000;
      send_ray(-base, 0, 0, 32'h10000, 0, 0, 1'b0, 0);
      send_ray(-base, 0, 0, -32'h10000, 0, 0, 1'b0, 0);
      send_ray(-base, base, 0, 32'h10000, 0, 0, 1'b0, 0);
      send_ray(-32'h10000, 0, 0, 0, 0, 0, 1'b0, 0);
      send_ray(-32'h10001, 0, 0, 0, 32'h10000, 0, 1'b0, 0);
      send_ray(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 1'b0, 0);
      send_ray(0, 0, 0, 32'h10000, 0, 0, 1'b1, 32'h8000);
      send_ray(0, 0, 0, 32'h10000, 0, 0, 1'b1, 32'h7fffffff);
      send_ray(-base, 0, 0, 32'h10000, 0, 0, 1'b1, 32'h10000);
      send_ray(-base, 0, 0, 32'h10000, 0, 0, 1'b1, 32'h7fffffff);
      send_ray(-base, 0, 0, 32'h10000, 0, 0, 1'b1, 0);
      send_ray(32'h80000000, 32'h7fffffff, 0, 1, -1, 0, 1'b0, 0);
      send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 32'h7fffffff);
      send_ray(32'h80000000, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 0);
      send_ray(-base, -base, -base, 1, 1, 1, 1'b0, 0);
      send_ray(-base, 0, 0, 32'h7fffffff, 0, 0, 1'b0, 0);
      send_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, -1, -1, -1, 1'b1, 66);
      wait_idle();

      // Random phases, each with its own box and idling mix.
      set_box(-32'h20000, -32'h8000, -32'h40000, 32'h30000, 32'h8000, 32'h10000, 66);
      random_rays(140);
      wait_idle();

      idle_pct = 69; stall_pct = 0;
      set_box(32'h80000000, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
      random_rays(110);
      wait_idle();

      idle_pct = 0; stall_pct = 69;
      set_box(32'h10000, 32'h10000, 32'h10000, -32'h10000, 32'h20000, -32'h20000, 65535);
      random_rays(110);
      wait_idle();

      idle_pct = 30; stall_pct = 30;
      set_box(-$urandom_range(0, 32'h200000), -$urandom_range(0, 32'h200000),
              -$urandom_range(0, 32'h200000), $urandom_range(0, 32'h200000),
              $urandom_range(0, 32'h200000), $urandom_range(0, 32'h200000),
              $urandom_range(0, 65535));
      random_rays(150);
      wait_idle();

      idle_pct = 0; stall_pct = 0;
      set_box(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h100);
      random_rays(140);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
